// ===== hdl/pbad_pkg.sv =====
// Shared types and constants for the pulse block average decimator.
`timescale 1ns / 1ps
`default_nettype none

package pbad_pkg;

    localparam int SCREEN_POINTS_DEF = 1000;
    localparam int SPAN_BITS_DEF     = 24;
    localparam int CNT_W             = 15;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CNT_W-1:0] GROUP_MAX = 15'h7FFF;

    typedef struct packed {
        logic        [31:0] frequency_in;
        logic        [31:0] delta_toa_in;
        logic        [23:0] width_in;
        logic signed [15:0] amplitude_in;
        logic               final_record;
    } t_in_word;

    typedef struct packed {
        logic        [31:0] frequency_avg;
        logic        [31:0] delta_toa_avg;
        logic        [23:0] width_avg;
        logic signed [15:0] amplitude_avg;
        logic [CNT_W-1:0]   samples_used;
        logic               final_point;
    } t_out_word;

    // One closed group on its way from the front to the back.
    typedef struct packed {
        logic        [46:0] freq_sum;
        logic        [46:0] dtoa_sum;
        logic        [38:0] width_sum;
        logic signed [30:0] amp_sum;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_group;

    typedef enum logic [1:0] {
        FR_RUN,
        FR_CALC,
        FR_SET
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/pulse_block_average_decimator_top.sv =====
// Top level of the pulse block average decimator.
//
// Input queue side: a record word is taken at a clock edge with push high and
// full low. Result queue side: while empty is low the oldest result word sits on
// o_out_word and leaves at an edge with pop high. The span register is written
// through i_cfg_data at an edge with i_cfg_valid and o_cfg_ready both high.
// A span write drops any partial group and derives the group size by a multiply
// with the reciprocal of SCREEN_POINTS: full stays high through the calc and
// set states, or only the set state when the span is at most SCREEN_POINTS.
// Records are summed in the front end; a closed group goes into a two-entry
// queue. The back end divides all four sums at once, one quotient bit a
// cycle, and a group of two or more records holds the back end until its
// quotients are in the output register. A single-record group skips the
// divider and goes from the queue straight into the output register; the
// back end takes no new group while a result waits to be popped.
// A result holds in the output register until popped; the back end then
// stops, the queue fills and full rises. Reset clears all sums, sets the
// group size to one and leaves both queues empty; the span is not reset.
`timescale 1ns / 1ps
`default_nettype none

module pulse_block_average_decimator_top #(
    parameter int SCREEN_POINTS = pbad_pkg::SCREEN_POINTS_DEF,
    parameter int SPAN_BITS     = pbad_pkg::SPAN_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [SPAN_BITS-1:0]   i_cfg_data,
    input  wire                    push,
    output logic                   full,
    input  wire pbad_pkg::t_in_word i_in_word,
    output logic                   empty,
    input  wire                    pop,
    output pbad_pkg::t_out_word    o_out_word
);

    logic              w_q_push;
    logic              w_q_full;
    logic              w_q_pop;
    logic              w_q_empty;
    pbad_pkg::t_group  w_q_in;
    pbad_pkg::t_group  w_q_out;

    pbad_front #(
        .SCREEN_POINTS (SCREEN_POINTS),
        .SPAN_BITS     (SPAN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_in_word   (i_in_word),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_in),
        .i_q_full    (w_q_full)
    );

    pbad_queue #(
        .DEPTH (pbad_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    pbad_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (w_q_out),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// ===== hdl/pbad_front.sv =====
// Front end: span register, group size calculation and per-field accumulation.
`timescale 1ns / 1ps
`default_nettype none

module pbad_front #(
    parameter int SCREEN_POINTS = pbad_pkg::SCREEN_POINTS_DEF,
    parameter int SPAN_BITS     = pbad_pkg::SPAN_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [SPAN_BITS-1:0]   i_cfg_data,
    input  wire                    i_push,
    output logic                   o_full,
    input  wire pbad_pkg::t_in_word i_in_word,
    output logic                   o_q_push,
    output pbad_pkg::t_group       o_q_data,
    input  wire                    i_q_full
);

    localparam int WIDE     = SPAN_BITS + 16;
    localparam logic [WIDE-1:0] SP_WIDE  = WIDE'(SCREEN_POINTS);

    // span / SCREEN_POINTS as (span * RECIP) >> SHIFT, exact for every span
    localparam int SP_LOG   = $clog2(SCREEN_POINTS);
    localparam int SHIFT    = SPAN_BITS + SP_LOG;
    localparam int RECIP_W  = SPAN_BITS + 1;
    localparam int PROD_W   = SPAN_BITS + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(SCREEN_POINTS) - 64'd1) / 64'(SCREEN_POINTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    pbad_pkg::t_front_state r_state, n_state;

    logic                        r_cfg_small;
    logic [SPAN_BITS-1:0]        r_cfg_dvd;
    logic [PROD_W-1:0]           r_prod;
    logic [pbad_pkg::CNT_W-1:0]  r_group_size;
    logic [pbad_pkg::CNT_W-1:0]  r_fill;
    logic [46:0]                 r_freq_sum;
    logic [46:0]                 r_dtoa_sum;
    logic [38:0]                 r_width_sum;
    logic signed [30:0]          r_amp_sum;

    logic                        w_cfg_fire;
    logic                        w_busy;
    logic                        w_accept;
    logic                        w_close;
    logic [PROD_W-1:0]           w_quot;
    logic [pbad_pkg::CNT_W-1:0]  w_size_calc;
    logic [pbad_pkg::CNT_W-1:0]  n_fill;
    logic [46:0]                 n_freq_sum;
    logic [46:0]                 n_dtoa_sum;
    logic [38:0]                 n_width_sum;
    logic signed [30:0]          n_amp_sum;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbad_pkg::FR_RUN: begin
                if (w_cfg_fire) begin
                    n_state = (WIDE'(i_cfg_data) <= SP_WIDE) ? pbad_pkg::FR_SET
                                                             : pbad_pkg::FR_CALC;
                end
            end
            pbad_pkg::FR_CALC: begin
                n_state = pbad_pkg::FR_SET;
            end
            pbad_pkg::FR_SET: begin
                n_state = pbad_pkg::FR_RUN;
            end
            default: begin
                n_state = pbad_pkg::FR_RUN;
            end
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            pbad_pkg::FR_RUN: begin
                o_cfg_ready = 1'b1;
                w_busy      = 1'b0;
            end
            default: begin
                o_cfg_ready = 1'b0;
                w_busy      = 1'b1;
            end
        endcase
    end

    assign w_cfg_fire = i_cfg_valid && o_cfg_ready;
    assign o_full     = w_busy || i_q_full;
    assign w_accept   = i_push && !o_full;

    assign w_quot      = r_prod >> SHIFT;
    assign w_size_calc = (w_quot >= PROD_W'(pbad_pkg::GROUP_MAX)) ? pbad_pkg::GROUP_MAX
                                                : (w_quot[pbad_pkg::CNT_W-1:0] + 15'd1);

    assign n_fill      = r_fill + 15'd1;
    assign n_freq_sum  = r_freq_sum + 47'(i_in_word.frequency_in);
    assign n_dtoa_sum  = r_dtoa_sum + 47'(i_in_word.delta_toa_in);
    assign n_width_sum = r_width_sum + 39'(i_in_word.width_in);
    assign n_amp_sum   = r_amp_sum + {{15{i_in_word.amplitude_in[15]}}, i_in_word.amplitude_in};
    assign w_close     = (n_fill >= r_group_size) || i_in_word.final_record;

    assign o_q_push           = w_accept && w_close;
    assign o_q_data.freq_sum  = n_freq_sum;
    assign o_q_data.dtoa_sum  = n_dtoa_sum;
    assign o_q_data.width_sum = n_width_sum;
    assign o_q_data.amp_sum   = n_amp_sum;
    assign o_q_data.count     = n_fill;
    assign o_q_data.last      = i_in_word.final_record;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pbad_pkg::FR_RUN;
            r_cfg_small  <= 1'b1;
            r_group_size <= 15'd1;
            r_fill       <= '0;
            r_freq_sum   <= '0;
            r_dtoa_sum   <= '0;
            r_width_sum  <= '0;
            r_amp_sum    <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_fire) begin
                // new range: drop any partial group
                r_cfg_small <= (WIDE'(i_cfg_data) <= SP_WIDE);
                r_fill      <= '0;
                r_freq_sum  <= '0;
                r_dtoa_sum  <= '0;
                r_width_sum <= '0;
                r_amp_sum   <= '0;
            end else if (w_accept) begin
                if (w_close) begin
                    r_fill      <= '0;
                    r_freq_sum  <= '0;
                    r_dtoa_sum  <= '0;
                    r_width_sum <= '0;
                    r_amp_sum   <= '0;
                end else begin
                    r_fill      <= n_fill;
                    r_freq_sum  <= n_freq_sum;
                    r_dtoa_sum  <= n_dtoa_sum;
                    r_width_sum <= n_width_sum;
                    r_amp_sum   <= n_amp_sum;
                end
            end
            if (r_state == pbad_pkg::FR_SET) begin
                r_group_size <= r_cfg_small ? 15'd1 : w_size_calc;
            end
        end
    end

    // span capture and reciprocal product
    always_ff @(posedge i_clk) begin
        if (w_cfg_fire) begin
            r_cfg_dvd <= i_cfg_data;
        end
        if (r_state == pbad_pkg::FR_CALC) begin
            r_prod <= PROD_W'(r_cfg_dvd) * PROD_W'(RECIP);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pbad_queue.sv =====
// Short queue of closed groups between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module pbad_queue #(
    parameter int DEPTH = pbad_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire pbad_pkg::t_group i_data,
    output logic              o_full,
    input  wire               i_pop,
    output pbad_pkg::t_group  o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_B = $clog2(DEPTH + 1);

    pbad_pkg::t_group   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_B-1:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == CNT_B'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : (r_wr + PTR_W'(1));
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : (r_rd + PTR_W'(1));
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_B'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_B'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pbad_back.sv =====
// Back end: divides group sums by the sample count and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module pbad_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire pbad_pkg::t_group i_q_data,
    input  wire                 i_q_empty,
    output logic                o_q_pop,
    output logic                o_empty,
    input  wire                 i_pop,
    output pbad_pkg::t_out_word o_out_word
);

    localparam int LANES = 4;
    localparam int QUO_W = 32;
    localparam int REM_W = 16;
    localparam int DVD_W = 47;
    localparam int STEP_W = $clog2(QUO_W);

    pbad_pkg::t_back_state r_state, n_state;

    logic [REM_W-1:0]            r_rem [LANES];
    logic [QUO_W-1:0]            r_quo [LANES];
    logic [pbad_pkg::CNT_W-1:0]  r_div_n;
    logic                        r_amp_neg;
    logic                        r_last;
    logic [STEP_W-1:0]           r_step;
    logic                        r_out_valid;
    pbad_pkg::t_out_word         r_out;

    logic                        w_single;
    logic                        w_load_div;
    logic                        w_pass;
    logic                        w_finish;
    logic [30:0]                 w_amp_mag;
    logic [DVD_W-1:0]            w_dvd   [LANES];
    logic [REM_W:0]              w_trial [LANES];
    logic                        w_ge    [LANES];
    logic [REM_W:0]              w_rem_n [LANES];
    logic [15:0]                 w_amp_q;

    assign w_single = (i_q_data.count == 15'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbad_pkg::BK_IDLE: begin
                if (!i_q_empty && !r_out_valid && !w_single) begin
                    n_state = pbad_pkg::BK_DIV;
                end
            end
            pbad_pkg::BK_DIV: begin
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = pbad_pkg::BK_DONE;
                end
            end
            pbad_pkg::BK_DONE: begin
                n_state = pbad_pkg::BK_IDLE;
            end
            default: begin
                n_state = pbad_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop    = 1'b0;
        w_load_div = 1'b0;
        w_pass     = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            pbad_pkg::BK_IDLE: begin
                o_q_pop    = !i_q_empty && !r_out_valid;
                w_load_div = o_q_pop && !w_single;
                w_pass     = o_q_pop && w_single;
            end
            pbad_pkg::BK_DIV: begin
            end
            pbad_pkg::BK_DONE: begin
                w_finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_amp_mag = i_q_data.amp_sum[30] ? 31'(-i_q_data.amp_sum)
                                            : 31'(i_q_data.amp_sum);
    assign w_dvd[0] = i_q_data.freq_sum;
    assign w_dvd[1] = i_q_data.dtoa_sum;
    assign w_dvd[2] = DVD_W'(i_q_data.width_sum);
    assign w_dvd[3] = DVD_W'(w_amp_mag);

    // every quotient fits 32 bits, so the upper sum bits are already below n
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_trial[k] = {r_rem[k], r_quo[k][QUO_W-1]};
            w_ge[k]    = (w_trial[k] >= (REM_W + 1)'(r_div_n));
            w_rem_n[k] = w_ge[k] ? (w_trial[k] - (REM_W + 1)'(r_div_n)) : w_trial[k];
        end
    end

    assign w_amp_q = r_amp_neg ? (16'd0 - r_quo[3][15:0]) : r_quo[3][15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbad_pkg::BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_div) begin
                r_step <= '0;
            end else if (r_state == pbad_pkg::BK_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_pass || w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_div) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= REM_W'(w_dvd[k][DVD_W-1:QUO_W]);
                r_quo[k] <= w_dvd[k][QUO_W-1:0];
            end
            r_div_n   <= i_q_data.count;
            r_amp_neg <= i_q_data.amp_sum[30];
            r_last    <= i_q_data.last;
        end else if (r_state == pbad_pkg::BK_DIV) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= w_rem_n[k][REM_W-1:0];
                r_quo[k] <= {r_quo[k][QUO_W-2:0], w_ge[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pass) begin
            r_out.frequency_avg <= i_q_data.freq_sum[31:0];
            r_out.delta_toa_avg <= i_q_data.dtoa_sum[31:0];
            r_out.width_avg     <= i_q_data.width_sum[23:0];
            r_out.amplitude_avg <= i_q_data.amp_sum[15:0];
            r_out.samples_used  <= i_q_data.count;
            r_out.final_point   <= i_q_data.last;
        end else if (w_finish) begin
            r_out.frequency_avg <= r_quo[0];
            r_out.delta_toa_avg <= r_quo[1];
            r_out.width_avg     <= r_quo[2][23:0];
            r_out.amplitude_avg <= w_amp_q;
            r_out.samples_used  <= r_div_n;
            r_out.final_point   <= r_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

endmodule

`default_nettype wire

// ===== hdl/pbad_checker.sv =====
// Port-level checks for the pulse block average decimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pbad_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_cfg_valid,
    input wire                  o_cfg_ready,
    input wire                  full,
    input wire                  empty,
    input wire                  pop,
    input wire pbad_pkg::t_out_word o_out_word
);

    // group size is computed right after a write, so no record may enter
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> full)
        else $error("record accepted while group size is being computed");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> full)
        else $error("input open while span divider busy");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_word.samples_used != '0))
        else $error("result word with zero samples");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && o_cfg_ready))
        else $error("block not idle after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_word)))
        else $error("waiting result word changed or vanished");

endmodule

bind pulse_block_average_decimator_top pbad_checker u_pbad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_out_word  (o_out_word)
);

`default_nettype wire

// ===== tb/pulse_block_average_decimator_top_test.sv =====
// Self-checking testbench for the pulse block average decimator top level.
`timescale 1ns / 1ps

module pulse_block_average_decimator_top_test;

    localparam int SCREEN_POINTS = pbad_pkg::SCREEN_POINTS_DEF;
    localparam int SPAN_BITS     = pbad_pkg::SPAN_BITS_DEF;
    localparam int CNT_W         = pbad_pkg::CNT_W;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [SPAN_BITS-1:0] i_cfg_data  = '0;
    logic                 push        = 1'b0;
    logic                 full;
    pbad_pkg::t_in_word   i_in_word   = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    pbad_pkg::t_out_word  o_out_word;

    pulse_block_average_decimator_top #(
        .SCREEN_POINTS(SCREEN_POINTS),
        .SPAN_BITS    (SPAN_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    // records waiting to be pushed, averages waiting to be popped
    pbad_pkg::t_in_word  records_to_send[$];
    pbad_pkg::t_out_word averages_due[$];

    // running group state of the predictor
    int unsigned     group_len;
    int unsigned     group_fill;
    logic [63:0]     freq_total;
    logic [63:0]     dtoa_total;
    logic [63:0]     width_total;
    longint          amp_total;

    int unsigned     fault_count = 0;
    int unsigned     cycle_count = 0;
    int unsigned     push_hold   = 0;
    int unsigned     pop_hold    = 0;
    bit              calm        = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned group_len_for(input logic [SPAN_BITS-1:0] span);
        longint unsigned g;
        if (span <= SCREEN_POINTS)
            return 1;
        g = span / SCREEN_POINTS + 1;
        if (g > int'(pbad_pkg::GROUP_MAX))
            g = int'(pbad_pkg::GROUP_MAX);
        return int'(g);
    endfunction

    task automatic clear_group_sums();
        group_fill  = 0;
        freq_total  = '0;
        dtoa_total  = '0;
        width_total = '0;
        amp_total   = 0;
    endtask

    // Adds one accepted record to the open group; closes it when full or final.
    task automatic fold_record(input pbad_pkg::t_in_word w);
        pbad_pkg::t_out_word avg;
        longint    n;
        freq_total  += w.frequency_in;
        dtoa_total  += w.delta_toa_in;
        width_total += w.width_in;
        amp_total   += longint'($signed(w.amplitude_in));
        group_fill++;
        if (group_fill < group_len && !w.final_record)
            return;
        n = longint'(group_fill);
        avg.frequency_avg = 32'(freq_total / 64'(n));
        avg.delta_toa_avg = 32'(dtoa_total / 64'(n));
        avg.width_avg     = 24'(width_total / 64'(n));
        // signed divide truncates toward zero
        avg.amplitude_avg = 16'(amp_total / n);
        avg.samples_used  = CNT_W'(group_fill);
        avg.final_point   = w.final_record;
        averages_due.push_back(avg);
        clear_group_sums();
    endtask

    task automatic check_average(input pbad_pkg::t_out_word got);
        pbad_pkg::t_out_word want;
        if (averages_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
                $display("unexpected word: f=%h d=%h w=%h a=%0d n=%0d last=%b",
                         got.frequency_avg, got.delta_toa_avg, got.width_avg,
                         got.amplitude_avg, got.samples_used, got.final_point);
            return;
        end
        want = averages_due.pop_front();
        if (got.frequency_avg !== want.frequency_avg ||
            got.delta_toa_avg !== want.delta_toa_avg ||
            got.width_avg     !== want.width_avg     ||
            got.amplitude_avg !== want.amplitude_avg ||
            got.samples_used  !== want.samples_used  ||
            got.final_point   !== want.final_point) begin
            fault_count++;
            if (fault_count <= REPORT_MAX) begin
                $display("mismatch exp: f=%h d=%h w=%h a=%0d n=%0d last=%b",
                         want.frequency_avg, want.delta_toa_avg, want.width_avg,
                         want.amplitude_avg, want.samples_used, want.final_point);
                $display("         got: f=%h d=%h w=%h a=%0d n=%0d last=%b",
                         got.frequency_avg, got.delta_toa_avg, got.width_avg,
                         got.amplitude_avg, got.samples_used, got.final_point);
            end
        end
    endtask

    // record driver
    always @(posedge i_clk) begin
        if (push && !full) begin
            fold_record(i_in_word);
            if (!calm && $urandom_range(0, 4) == 0)
                push_hold = $urandom_range(1, 4);
        end
        if (!push || !full) begin
            if (push_hold > 0) begin
                push_hold--;
                push <= 1'b0;
            end else if (records_to_send.size() != 0) begin
                i_in_word <= records_to_send.pop_front();
                push      <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // average monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_average(o_out_word);
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                pop_hold = $urandom_range(1, 4);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] skewed_value(input int unsigned bits);
        logic [31:0] mask;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : (32'h1 << bits) - 32'h1;
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    task automatic queue_record(input logic [31:0] f, input logic [31:0] d,
                                input logic [23:0] w, input logic [15:0] a,
                                input logic last);
        pbad_pkg::t_in_word r;
        r.frequency_in = f;
        r.delta_toa_in = d;
        r.width_in     = w;
        r.amplitude_in = a;
        r.final_record = last;
        records_to_send.push_back(r);
    endtask

    task automatic queue_random(input int unsigned count, input int unsigned final_odds);
        for (int unsigned i = 0; i < count; i++)
            queue_record(skewed_value(32), skewed_value(32), 24'(skewed_value(24)),
                         16'(skewed_value(16)), $urandom_range(1, final_odds) == 1);
    endtask

    // Waits until every pushed word is in and every average is out, then a bit more.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (records_to_send.size() != 0 || push || averages_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_span(input logic [SPAN_BITS-1:0] span);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= span;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // a span write drops the open group
        group_len = group_len_for(span);
        clear_group_sums();
    endtask

    initial begin
        group_len = 1;
        clear_group_sums();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset span: every record passes through
        queue_record(32'h0, 32'h0, 24'h0, 16'h0000, 1'b0);
        queue_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'h7FFF, 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'h8000, 1'b1);
        queue_record($urandom, $urandom, 24'($urandom), 16'hFFFF, 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'($urandom), 1'b1);
        wait_drained();

        // groups of three
        write_span(SPAN_BITS'(2999));
        repeat (3) queue_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'h7FFF, 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'hFFFF, 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'hFFFF, 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'h0000, 1'b0);
        repeat (3) queue_record(32'h0, 32'h0, 24'h0, 16'h8000, 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'($urandom), 1'b0);
        queue_record($urandom, $urandom, 24'($urandom), 16'($urandom), 1'b1);
        queue_record($urandom, $urandom, 24'($urandom), 16'($urandom), 1'b1);
        repeat (3) queue_record($urandom, $urandom, 24'($urandom), 16'($urandom), 1'b0);
        // left open on purpose; the next span write must throw it away
        repeat (2) queue_record($urandom, $urandom, 24'($urandom), 16'($urandom), 1'b0);
        wait_drained();

        write_span(SPAN_BITS'(1001));
        queue_random(200, 10);
        wait_drained();

        write_span('0);
        queue_random(100, 4);
        wait_drained();

        // widest span: groups only ever close on a final mark
        write_span({SPAN_BITS{1'b1}});
        queue_random(60, 8);
        wait_drained();

        write_span(SPAN_BITS'(SCREEN_POINTS));
        queue_random(100, 6);
        wait_drained();

        // sender stops halfway until all averages are out
        write_span(SPAN_BITS'(4999));
        queue_random(125, 15);
        wait_drained();
        queue_random(125, 15);
        wait_drained();

        write_span(SPAN_BITS'($urandom_range(1001, 40999)));
        queue_random(300, 30);
        wait_drained();

        write_span(SPAN_BITS'(15999));
        queue_random(250, 40);
        wait_drained();

        calm = 1'b1;
        write_span(SPAN_BITS'(2000));
        queue_random(390, 12);
        wait_drained();

        if (fault_count == 0 && averages_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
